// ===== src/scc_pkg.sv =====
// Package for the snoopy coherence controller: line states, snoop kinds,
// controller states, command/status structs and register indexes.
// No dependencies.
`default_nettype none

package scc_pkg;

    // Coherence state of one line
    typedef enum logic [2:0] {
        ST_I = 3'd0,
        ST_S = 3'd1,
        ST_E = 3'd2,
        ST_M = 3'd3,
        ST_O = 3'd4
    } lstate_t;

    // Bus request seen by the other caches
    typedef enum logic [1:0] {
        SNP_NONE,
        SNP_RD,
        SNP_RDX,
        SNP_UPGR
    } snoop_t;

    // Controller states
    typedef enum logic [2:0] {
        C_CLEAR,
        C_IDLE,
        C_LOOK,
        C_LOOK_WAIT,
        C_COMMIT,
        C_SNOOP,
        C_SNOOP_WAIT,
        C_FINISH
    } ctrl_state_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_PROTOCOL = 3'd0;
    localparam logic [2:0] CFG_READ_HIT = 3'd1;
    localparam logic [2:0] CFG_WRITE_HIT = 3'd2;
    localparam logic [2:0] CFG_MEMORY = 3'd3;
    localparam logic [2:0] CFG_TRANSFER = 3'd4;

    localparam logic MODE_MESI = 1'b0;

    // Controller to datapath
    typedef struct packed {
        logic clr;     // write invalid at scan address, step
        logic load;    // latch the item, set up requester scan
        logic look;    // read requester line, step
        logic commit;  // update requester line, set up snoop scan
        logic snoop;   // read any line for snooping, step
        logic finish;  // charge latency, present result
    } scc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic line_last;
        logic proc_last;
        logic req_ok;
    } scc_status_t;

    // Saturating two-bit event count
    function automatic logic [1:0] sat_inc(input logic [1:0] c, input logic en);
        logic [1:0] r;
        r = c;
        if (en && c != 2'd3)
            r = c + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/scc_ctrl.sv =====
// Sequencer of the snoopy coherence controller: clearing pass, requester
// lookup, line update, snoop sweep and result. Depends on scc_pkg.
`default_nettype none

module scc_ctrl
    import scc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire scc_status_t status,
    output scc_cmd_t         cmd,
    output logic             busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            C_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.line_last && status.proc_last)
                    state_next = C_IDLE;
            end
            C_IDLE:
            begin
                if (start && status.req_ok)
                begin
                    cmd.load = 1'b1;
                    state_next = C_LOOK;
                end
            end
            C_LOOK:
            begin
                cmd.look = 1'b1;
                if (status.line_last)
                    state_next = C_LOOK_WAIT;
            end
            C_LOOK_WAIT:  state_next = C_COMMIT;
            C_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = C_SNOOP;
            end
            C_SNOOP:
            begin
                cmd.snoop = 1'b1;
                if (status.line_last && status.proc_last)
                    state_next = C_SNOOP_WAIT;
            end
            C_SNOOP_WAIT: state_next = C_FINISH;
            C_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = C_IDLE;
            end
            default:      state_next = C_IDLE;
        endcase
    end

    assign busy = (state_reg != C_IDLE);

endmodule

`default_nettype wire

// ===== src/scc_dp.sv =====
// Datapath of the snoopy coherence controller: tag, state and stamp
// memories, scan counters, protocol rules, latency total. Depends on scc_pkg.
`default_nettype none

module scc_dp
    import scc_pkg::*;
#(
    parameter int PROCESSORS   = 4,
    parameter int LINES        = 64,
    parameter int BLOCK_BYTES  = 64,
    parameter int ADDRESS_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire scc_cmd_t    cmd,
    output scc_status_t      status,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  requester,
    input  wire logic [31:0] address,
    input  wire logic        is_write,
    input  wire logic        shared_copy,
    output logic             done,
    output logic             hit,
    output logic [2:0]       line_state,
    output logic             memory_fetch,
    output logic             victim_writeback,
    output logic [1:0]       invalidation_count,
    output logic [1:0]       flush_count,
    output logic [1:0]       transfer_count,
    output logic [15:0]      added_cycles,
    output logic [47:0]      total_cycles
);

    localparam int ENTRIES = PROCESSORS * LINES;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LW = $clog2(LINES);
    localparam int PW = $clog2(PROCESSORS);
    localparam int OFF = $clog2(BLOCK_BYTES);
    localparam int TAG_W = 32 - OFF;
    localparam logic [63:0] AM64 = (ADDRESS_BITS >= 64) ? {64{1'b1}}
                                   : ((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [31:0] AMASK = AM64[31:0];

    // Configuration registers
    logic        mode_reg;
    logic [15:0] rh_reg, wh_reg, memc_reg, xfer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MESI;
            rh_reg   <= 16'd1;
            wh_reg   <= 16'd1;
            memc_reg <= 16'd100;
            xfer_reg <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROTOCOL:  mode_reg <= cfg_data[0];
                CFG_READ_HIT:  rh_reg   <= cfg_data;
                CFG_WRITE_HIT: wh_reg   <= cfg_data;
                CFG_MEMORY:    memc_reg <= cfg_data;
                CFG_TRANSFER:  xfer_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Item registers
    logic [TAG_W-1:0] tag_reg;
    logic [PW-1:0]    req_reg;
    logic             wr_reg, copy_reg;
    logic [31:0]      addr_masked;

    assign addr_masked = address & AMASK;
    assign status.req_ok = (32'(requester) < PROCESSORS);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg  <= addr_masked[31:OFF];
            req_reg  <= PW'(requester);
            wr_reg   <= is_write;
            copy_reg <= shared_copy;
        end
    end

    // Scan counters: line within cache, cache, base entry of cache
    logic [LW-1:0]    j_reg;
    logic [PW-1:0]    pc_reg;
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             step;

    assign status.line_last = (j_reg == LW'(LINES - 1));
    assign status.proc_last = (pc_reg == PW'(PROCESSORS - 1));
    assign rd_addr = base_reg + IDX_W'(j_reg);
    assign step = cmd.clr | cmd.look | cmd.snoop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg    <= '0;
            pc_reg   <= '0;
            base_reg <= '0;
        end
        else if (cmd.load)
        begin
            j_reg    <= '0;
            pc_reg   <= PW'(requester);
            base_reg <= IDX_W'(32'(requester) * LINES);
        end
        else if (cmd.commit)
        begin
            j_reg    <= '0;
            pc_reg   <= '0;
            base_reg <= '0;
        end
        else if (step)
        begin
            if (status.line_last)
            begin
                j_reg    <= '0;
                pc_reg   <= pc_reg + PW'(1);
                base_reg <= base_reg + IDX_W'(LINES);
            end
            else
                j_reg <= j_reg + LW'(1);
        end
    end

    // Read pipe: tags travelling with the registered memory data
    logic             pv_reg, pph_reg, pfirst_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic [PW-1:0]    ppc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= cmd.look | cmd.snoop;
    end

    always_ff @(posedge clk)
    begin
        pph_reg    <= cmd.snoop;
        pidx_reg   <= rd_addr;
        ppc_reg    <= pc_reg;
        pfirst_reg <= (j_reg == '0);
    end

    // Memories
    lstate_t          st_mem [ENTRIES];
    logic [TAG_W-1:0] tag_mem [ENTRIES];
    logic [31:0]      stamp_mem [ENTRIES];
    lstate_t          st_rd_reg;
    logic [TAG_W-1:0] tag_rd_reg;
    logic [31:0]      stamp_rd_reg;
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    lstate_t          st_wdata;
    logic             fill_we;
    logic [IDX_W-1:0] line_idx;
    logic [31:0]      fc_reg [PROCESSORS];

    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        st_rd_reg <= st_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            tag_mem[line_idx]   <= tag_reg;
            stamp_mem[line_idx] <= fc_reg[req_reg];
        end
        tag_rd_reg   <= tag_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
    end

    // Requester lookup: hit, first invalid line, oldest fill
    logic             tag_eq, look_act;
    logic             hit_reg, finv_reg;
    logic [IDX_W-1:0] hidx_reg, vidx_reg, midx_reg;
    lstate_t          hst_reg, mst_reg;
    logic [31:0]      mn_reg;

    assign tag_eq = (st_rd_reg != ST_I) && (tag_rd_reg == tag_reg);
    assign look_act = pv_reg && !pph_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            finv_reg <= 1'b0;
        end
        else if (look_act)
        begin
            if (tag_eq)
            begin
                hit_reg  <= 1'b1;
                hidx_reg <= pidx_reg;
                hst_reg  <= st_rd_reg;
            end
            if (st_rd_reg == ST_I && !finv_reg)
            begin
                finv_reg <= 1'b1;
                vidx_reg <= pidx_reg;
            end
            if (pfirst_reg || stamp_rd_reg <= mn_reg)
            begin
                mn_reg   <= stamp_rd_reg;
                midx_reg <= pidx_reg;
                mst_reg  <= st_rd_reg;
            end
        end
    end

    // Requester update rules
    lstate_t     new_st;
    snoop_t      kind;
    logic [15:0] lat;
    logic        wb;

    always_comb
    begin
        line_idx = hit_reg ? hidx_reg : (finv_reg ? vidx_reg : midx_reg);
        new_st = hst_reg;
        kind = SNP_NONE;
        if (hit_reg)
        begin
            if (wr_reg)
            begin
                if (mode_reg == MODE_MESI)
                begin
                    if (hst_reg == ST_S)
                    begin
                        new_st = ST_M;
                        kind = SNP_UPGR;
                    end
                    else if (hst_reg == ST_E)
                        new_st = ST_M;
                end
                else
                begin
                    new_st = ST_M;
                    if (hst_reg == ST_S || hst_reg == ST_O)
                        kind = SNP_UPGR;
                end
            end
        end
        else
        begin
            new_st = wr_reg ? ST_M : (copy_reg ? ST_S : ST_E);
            kind = wr_reg ? SNP_RDX : SNP_RD;
        end
        if (hit_reg)
            lat = wr_reg ? wh_reg : rh_reg;
        else
            lat = copy_reg ? xfer_reg : memc_reg;
        wb = !hit_reg && !finv_reg && (mst_reg == ST_M || mst_reg == ST_O);
    end

    assign fill_we = cmd.commit && !hit_reg;

    // Fill counters, one per cache
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PROCESSORS; i++)
                fc_reg[i] <= '0;
        end
        else if (fill_we)
            fc_reg[req_reg] <= fc_reg[req_reg] + 32'd1;
    end

    // Snoop rules for one matching line
    snoop_t  kind_reg;
    logic    snp_act;
    lstate_t snp_ns;
    logic    d_inv, d_flush, d_xfer;

    assign snp_act = pv_reg && pph_reg && (ppc_reg != req_reg) && tag_eq;

    always_comb
    begin
        snp_ns = st_rd_reg;
        d_inv = 1'b0;
        d_flush = 1'b0;
        d_xfer = 1'b0;
        if (mode_reg == MODE_MESI)
        begin
            case (kind_reg)
                SNP_RDX:
                begin
                    snp_ns = ST_I;
                    d_inv = 1'b1;
                    d_flush = 1'b1;
                end
                SNP_RD:
                begin
                    if (st_rd_reg == ST_M || st_rd_reg == ST_E)
                    begin
                        snp_ns = ST_S;
                        d_flush = 1'b1;
                    end
                    else if (st_rd_reg == ST_S)
                        d_flush = 1'b1;
                end
                SNP_UPGR:
                begin
                    snp_ns = ST_I;
                    d_inv = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            case (kind_reg)
                SNP_UPGR:
                begin
                    if (st_rd_reg == ST_S || st_rd_reg == ST_O)
                    begin
                        snp_ns = ST_I;
                        d_inv = 1'b1;
                    end
                end
                SNP_RDX:
                begin
                    d_xfer = (st_rd_reg == ST_E);
                    d_flush = (st_rd_reg == ST_M || st_rd_reg == ST_O);
                    snp_ns = ST_I;
                    d_inv = 1'b1;
                end
                SNP_RD:
                begin
                    d_flush = (st_rd_reg == ST_M || st_rd_reg == ST_O);
                    if (st_rd_reg == ST_M)
                        snp_ns = ST_O;
                    else if (st_rd_reg == ST_E)
                        snp_ns = ST_S;
                    d_xfer = (st_rd_reg == ST_S || st_rd_reg == ST_E);
                end
                default: ;
            endcase
        end
    end

    // State memory write port
    always_comb
    begin
        st_we = 1'b0;
        st_waddr = rd_addr;
        st_wdata = ST_I;
        if (cmd.clr)
            st_we = 1'b1;
        else if (cmd.commit)
        begin
            st_we = 1'b1;
            st_waddr = line_idx;
            st_wdata = new_st;
        end
        else if (snp_act)
        begin
            st_we = 1'b1;
            st_waddr = pidx_reg;
            st_wdata = snp_ns;
        end
    end

    // Result registers
    logic        res_hit, res_mem, res_wb;
    lstate_t     res_st;
    logic [15:0] res_lat;
    logic [1:0]  inv_reg, flush_reg, xfer_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_hit  <= hit_reg;
            res_st   <= new_st;
            res_mem  <= !hit_reg && !copy_reg;
            res_wb   <= wb;
            res_lat  <= lat;
            kind_reg <= kind;
        end
        if (cmd.load)
        begin
            inv_reg      <= '0;
            flush_reg    <= '0;
            xfer_cnt_reg <= '0;
        end
        else if (snp_act)
        begin
            inv_reg      <= sat_inc(inv_reg, d_inv);
            flush_reg    <= sat_inc(flush_reg, d_flush);
            xfer_cnt_reg <= sat_inc(xfer_cnt_reg, d_xfer);
        end
    end

    // Saturating time total and result strobe
    logic [47:0] total_reg;
    logic [48:0] total_sum;
    logic        done_reg;

    assign total_sum = {1'b0, total_reg} + 49'(res_lat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
                total_reg <= total_sum[48] ? {48{1'b1}} : total_sum[47:0];
        end
    end

    assign done = done_reg;
    assign hit = res_hit;
    assign line_state = res_st;
    assign memory_fetch = res_mem;
    assign victim_writeback = res_wb;
    assign invalidation_count = inv_reg;
    assign flush_count = flush_reg;
    assign transfer_count = xfer_cnt_reg;
    assign added_cycles = res_lat;
    assign total_cycles = total_reg;

endmodule

`default_nettype wire

// ===== src/snoopy_coherence_controller_core.sv =====
// Channel    Signals                                       Handshake
// access     requester, address, is_write, shared_copy     start & !busy
// result     hit .. total_cycles                           done, one cycle
// config     cfg_we, cfg_index, cfg_data                   cfg_we, while idle
//
// An access reads one line of the requester's tag store per cycle, then one
// line of every store per cycle for snooping, through memories with a single
// read port. After reset a clearing pass marks all lines invalid; busy is
// high meanwhile. A requester beyond PROCESSORS is taken and dropped.
// Results cannot be stalled.
// Top level; depends on scc_pkg, scc_ctrl and scc_dp.
`default_nettype none

module snoopy_coherence_controller_core
    import scc_pkg::*;
#(
    parameter int PROCESSORS   = 4,
    parameter int LINES        = 64,
    parameter int BLOCK_BYTES  = 64,
    parameter int ADDRESS_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  requester,
    input  wire logic [31:0] address,
    input  wire logic        is_write,
    input  wire logic        shared_copy,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic             hit,
    output logic [2:0]       line_state,
    output logic             memory_fetch,
    output logic             victim_writeback,
    output logic [1:0]       invalidation_count,
    output logic [1:0]       flush_count,
    output logic [1:0]       transfer_count,
    output logic [15:0]      added_cycles,
    output logic [47:0]      total_cycles
);

    scc_cmd_t    cmd;
    scc_status_t status;

    scc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    scc_dp #(
        .PROCESSORS   (PROCESSORS),
        .LINES        (LINES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .requester          (requester),
        .address            (address),
        .is_write           (is_write),
        .shared_copy        (shared_copy),
        .done               (done),
        .hit                (hit),
        .line_state         (line_state),
        .memory_fetch       (memory_fetch),
        .victim_writeback   (victim_writeback),
        .invalidation_count (invalidation_count),
        .flush_count        (flush_count),
        .transfer_count     (transfer_count),
        .added_cycles       (added_cycles),
        .total_cycles       (total_cycles)
    );

`ifndef SYNTHESIS
    // Result only once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // A valid access starts work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && status.req_ok) |=> busy)
        else $error("access not started");

    // Requester never ends invalid
    a_state_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (line_state != ST_I))
        else $error("requester line left invalid");

    // A hit fetches nothing and evicts nothing
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!memory_fetch && !victim_writeback))
        else $error("hit with fill side effects");
`endif

endmodule

`default_nettype wire

// ===== tb/scc_coherence_checker.sv =====
// Checker for the snoopy coherence controller: tracks register writes and
// accepted accesses, keeps its own copy of every tag store and compares each
// result. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_coherence_checker
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  requester,
    input  logic [31:0] address,
    input  logic        is_write,
    input  logic        shared_copy,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        done,
    input  logic        hit,
    input  logic [2:0]  line_state,
    input  logic        memory_fetch,
    input  logic        victim_writeback,
    input  logic [1:0]  invalidation_count,
    input  logic [1:0]  flush_count,
    input  logic [1:0]  transfer_count,
    input  logic [15:0] added_cycles,
    input  logic [47:0] total_cycles,
    output int          fail_count,
    output int          pending
);

    localparam int NPROC = 4;
    localparam int NLINE = 64;
    localparam logic [47:0] TOTAL_SAT = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        hit;
        logic [2:0]  line_state;
        logic        memory_fetch;
        logic        victim_writeback;
        logic [1:0]  inv;
        logic [1:0]  flush;
        logic [1:0]  xfer;
        logic [15:0] added;
        logic [47:0] total;
    } access_result_t;

    // Shadow copy of the tag stores and registers
    logic [25:0] tag_mem   [NPROC][NLINE];
    lstate_t     state_mem [NPROC][NLINE];
    logic [31:0] stamp_mem [NPROC][NLINE];
    logic [31:0] fill_cnt  [NPROC];
    logic [47:0] elapsed;
    logic        moesi;
    logic [15:0] rd_hit_lat, wr_hit_lat, mem_lat, xfer_lat;
    logic [1:0]  n_inv, n_flush, n_xfer;

    access_result_t awaited[$];

    assign pending = awaited.size();

    function automatic logic [1:0] bump(input logic [1:0] c);
        return (c == 2'd3) ? c : c + 2'd1;
    endfunction

    function automatic int find_line(input int p, input logic [25:0] tag);
        for (int j = 0; j < NLINE; j++)
            if (state_mem[p][j] != ST_I && tag_mem[p][j] == tag)
                return j;
        return -1;
    endfunction

    // Snoop response of one other cache
    function automatic void snoop_cache(input int p, input logic [25:0] tag,
                                        input snoop_t kind);
        int f;
        lstate_t s;
        f = find_line(p, tag);
        if (f < 0)
            return;
        s = state_mem[p][f];
        if (!moesi) begin
            if (kind == SNP_RDX) begin
                state_mem[p][f] = ST_I;
                n_inv = bump(n_inv);
                n_flush = bump(n_flush);
            end else if (kind == SNP_RD) begin
                if (s == ST_M || s == ST_E) begin
                    state_mem[p][f] = ST_S;
                    n_flush = bump(n_flush);
                end else if (s == ST_S) begin
                    n_flush = bump(n_flush);
                end
            end else begin
                state_mem[p][f] = ST_I;
                n_inv = bump(n_inv);
            end
        end else begin
            if (kind == SNP_UPGR) begin
                if (s == ST_S || s == ST_O) begin
                    state_mem[p][f] = ST_I;
                    n_inv = bump(n_inv);
                end
            end else if (kind == SNP_RDX) begin
                if (s == ST_E)
                    n_xfer = bump(n_xfer);
                if (s == ST_M || s == ST_O)
                    n_flush = bump(n_flush);
                state_mem[p][f] = ST_I;
                n_inv = bump(n_inv);
            end else begin
                if (s == ST_M || s == ST_O)
                    n_flush = bump(n_flush);
                if (s == ST_M)
                    state_mem[p][f] = ST_O;
                else if (s == ST_E)
                    state_mem[p][f] = ST_S;
                if (s == ST_S || s == ST_E)
                    n_xfer = bump(n_xfer);
            end
        end
    endfunction

    function automatic void snoop_others(input int req, input logic [25:0] tag,
                                         input snoop_t kind);
        for (int i = 0; i < NPROC; i++)
            if (i != req)
                snoop_cache(i, tag, kind);
    endfunction

    // Expected outcome of one access; updates the shadow state
    function automatic access_result_t predict_access(input int req,
                                                      input logic [31:0] addr,
                                                      input logic wr,
                                                      input logic copy);
        access_result_t r;
        logic [25:0] tag;
        logic [31:0] mn;
        lstate_t s;
        int f, k;
        r = '0;
        tag = addr[31:6];
        n_inv = 0;
        n_flush = 0;
        n_xfer = 0;
        f = find_line(req, tag);
        if (f >= 0) begin
            k = f;
            s = state_mem[req][k];
            r.hit = 1'b1;
            if (!wr) begin
                r.added = rd_hit_lat;
            end else begin
                r.added = wr_hit_lat;
                if (!moesi) begin
                    if (s == ST_S) begin
                        state_mem[req][k] = ST_M;
                        snoop_others(req, tag, SNP_UPGR);
                    end else if (s == ST_E) begin
                        state_mem[req][k] = ST_M;
                    end
                end else begin
                    state_mem[req][k] = ST_M;
                    if (s == ST_S || s == ST_O)
                        snoop_others(req, tag, SNP_UPGR);
                end
            end
        end else begin
            // Victim: first invalid line, else oldest stamp, last index on ties
            k = -1;
            for (int j = 0; j < NLINE; j++)
                if (k < 0 && state_mem[req][j] == ST_I)
                    k = j;
            if (k < 0) begin
                mn = stamp_mem[req][0];
                for (int j = 0; j < NLINE; j++)
                    if (stamp_mem[req][j] <= mn) begin
                        mn = stamp_mem[req][j];
                        k = j;
                    end
            end
            stamp_mem[req][k] = fill_cnt[req];
            fill_cnt[req] = fill_cnt[req] + 1;
            r.victim_writeback = (state_mem[req][k] == ST_M ||
                                  state_mem[req][k] == ST_O);
            tag_mem[req][k] = tag;
            r.memory_fetch = !copy;
            r.added = copy ? xfer_lat : mem_lat;
            if (!wr) begin
                state_mem[req][k] = copy ? ST_S : ST_E;
                snoop_others(req, tag, SNP_RD);
            end else begin
                state_mem[req][k] = ST_M;
                snoop_others(req, tag, SNP_RDX);
            end
        end
        if (TOTAL_SAT - elapsed < {32'd0, r.added})
            elapsed = TOTAL_SAT;
        else
            elapsed = elapsed + r.added;
        r.line_state = state_mem[req][k];
        r.inv = n_inv;
        r.flush = n_flush;
        r.xfer = n_xfer;
        r.total = elapsed;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [47:0] exp_v,
                                        input logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Watch the channels
    always @(posedge clk or negedge rst_n) begin
        access_result_t e;
        if (!rst_n) begin
            for (int p = 0; p < NPROC; p++) begin
                fill_cnt[p] = 0;
                for (int j = 0; j < NLINE; j++) begin
                    state_mem[p][j] = ST_I;
                    tag_mem[p][j] = '0;
                    stamp_mem[p][j] = '0;
                end
            end
            elapsed = '0;
            moesi = MODE_MESI;
            rd_hit_lat = 16'd1;
            wr_hit_lat = 16'd1;
            mem_lat = 16'd100;
            xfer_lat = 16'd10;
            awaited.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PROTOCOL: moesi = cfg_data[0];
                    CFG_READ_HIT: rd_hit_lat = cfg_data;
                    CFG_WRITE_HIT: wr_hit_lat = cfg_data;
                    CFG_MEMORY: mem_lat = cfg_data;
                    CFG_TRANSFER: xfer_lat = cfg_data;
                    default: ;
                endcase
            end
            if (done) begin
                if (awaited.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    e = awaited.pop_front();
                    check_field("hit", e.hit, hit);
                    check_field("line_state", e.line_state, line_state);
                    check_field("memory_fetch", e.memory_fetch, memory_fetch);
                    check_field("victim_writeback", e.victim_writeback,
                                victim_writeback);
                    check_field("invalidation_count", e.inv, invalidation_count);
                    check_field("flush_count", e.flush, flush_count);
                    check_field("transfer_count", e.xfer, transfer_count);
                    check_field("added_cycles", e.added, added_cycles);
                    check_field("total_cycles", e.total, total_cycles);
                end
            end
            if (start && !busy)
                awaited.push_back(predict_access(requester, address, is_write,
                                                 shared_copy));
        end
    end

endmodule

// ===== tb/snoopy_coherence_controller_core_test.sv =====
// Top of the snoopy coherence controller testbench: clock, reset, access and
// register stimulus, watchdog and verdict. Depends on scc_pkg,
// snoopy_coherence_controller_core and scc_coherence_checker.
`timescale 1ns / 1ps

module snoopy_coherence_controller_core_test;
    import scc_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 205;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  requester;
    logic [31:0] address;
    logic        is_write;
    logic        shared_copy;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic        hit;
    logic [2:0]  line_state;
    logic        memory_fetch;
    logic        victim_writeback;
    logic [1:0]  invalidation_count;
    logic [1:0]  flush_count;
    logic [1:0]  transfer_count;
    logic [15:0] added_cycles;
    logic [47:0] total_cycles;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [25:0] pool_base;

    snoopy_coherence_controller_core dut (.*);

    scc_coherence_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: cycles in which nothing moves
    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("snoopy_coherence_controller_core_test failed");
            $finish;
        end
    end

    // Sender gap: mostly short, now and then long enough to span an access
    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                        : $urandom_range(0, 2);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // One access item, held until the block takes it
    task automatic send_access(input logic [1:0] req, input logic [31:0] addr,
                               input logic wr, input logic copy);
        sender_gap();
        start <= 1'b1;
        requester <= req;
        address <= addr;
        is_write <= wr;
        shared_copy <= copy;
        do @(posedge clk); while (busy);
    endtask

    // Register writes only once every result is in
    task automatic write_regs(input logic mode, input logic [15:0] rd_lat,
                              input logic [15:0] wr_lat, input logic [15:0] mem_lat,
                              input logic [15:0] xfer_lat);
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PROTOCOL;
        cfg_data <= {15'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_READ_HIT;
        cfg_data <= rd_lat;
        @(posedge clk);
        cfg_index <= CFG_WRITE_HIT;
        cfg_data <= wr_lat;
        @(posedge clk);
        cfg_index <= CFG_MEMORY;
        cfg_data <= mem_lat;
        @(posedge clk);
        cfg_index <= CFG_TRANSFER;
        cfg_data <= xfer_lat;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random access: a block pool larger than one store so lines get evicted,
    // a tiny pool so caches share, and some fully random addresses
    task automatic random_access();
        int r;
        logic [25:0] tag;
        r = $urandom_range(0, 99);
        if (r < 55)
            tag = pool_base + 26'($urandom_range(0, 95));
        else if (r < 90)
            tag = pool_base + 26'($urandom_range(0, 5));
        else
            tag = 26'($urandom);
        send_access(2'($urandom_range(0, 3)), {tag, 6'($urandom)},
                    1'($urandom), 1'($urandom));
    endtask

    initial begin
        start = 1'b0;
        requester = '0;
        address = '0;
        is_write = 1'b0;
        shared_copy = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PROTOCOL;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset registers (MESI)
        send_access(2'd0, 32'h0000_0000, 1'b0, 1'b0);   // read miss from memory: E
        send_access(2'd0, 32'h0000_0004, 1'b1, 1'b0);   // write hit on E: M
        send_access(2'd1, 32'h0000_0010, 1'b0, 1'b1);   // BusRd against M: flush
        send_access(2'd1, 32'h0000_0020, 1'b1, 1'b0);   // write hit on S: upgrade
        send_access(2'd2, 32'h0000_0000, 1'b1, 1'b1);   // write miss: BusRdX
        send_access(2'd3, 32'hFFFF_FFFF, 1'b0, 1'b1);   // top address, read miss
        send_access(2'd3, 32'hFFFF_FFC0, 1'b0, 1'b0);   // read hit
        send_access(2'd2, 32'hFFFF_FFFF, 1'b0, 1'b0);   // S snooped by BusRd
        // MOESI: owner and cache-to-cache cases, extreme latencies
        write_regs(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_access(2'd0, 32'h0000_1000, 1'b1, 1'b0);   // M
        send_access(2'd1, 32'h0000_1000, 1'b0, 1'b1);   // M to O, flush
        send_access(2'd2, 32'h0000_1000, 1'b0, 1'b1);   // O flushes again
        send_access(2'd0, 32'h0000_1000, 1'b1, 1'b0);   // write hit on O: upgrade
        send_access(2'd3, 32'h0000_2000, 1'b0, 1'b0);   // E
        send_access(2'd1, 32'h0000_2000, 1'b0, 1'b1);   // E to S, transfer
        send_access(2'd2, 32'h0000_2000, 1'b1, 1'b0);   // BusRdX on S
        send_access(2'd0, 32'h0000_3000, 1'b1, 1'b0);   // M
        send_access(2'd1, 32'h0000_3000, 1'b0, 1'b1);   // leaves an O line
        // Back to MESI with the O line still held
        write_regs(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_access(2'd0, 32'h0000_3000, 1'b0, 1'b0);   // read hit on O
        send_access(2'd0, 32'h0000_3000, 1'b1, 1'b0);   // write hit on O stays O
        send_access(2'd2, 32'h0000_3000, 1'b0, 1'b1);   // BusRd against O

        // Random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_regs(1'b0, 16'd1, 16'd1, 16'd100, 16'd10);
                1: write_regs(1'b1, 16'd1, 16'd2, 16'd100, 16'd10);
                2: write_regs(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: write_regs(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: write_regs(1'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
            endcase
            pool_base = 26'($urandom);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_access();
        end
        start <= 1'b0;

        // Drain, then settle
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("snoopy_coherence_controller_core_test passed");
        else
            $display("snoopy_coherence_controller_core_test failed");
        $finish;
    end

endmodule
